[rtl/tcqa_pkg.sv]
// ----------------------------------------------------------------------------
// tcqa_pkg
// Shared types and constants of the channel qualifier with moving average.
// ----------------------------------------------------------------------------
package tcqa_pkg;

    localparam int CHANNELS    = 5;
    localparam int RING_DEPTH  = 8;
    localparam int OFFSET_REGS = 5;

    localparam int CH_IN_W   = 3;
    localparam int SAMPLE_W  = 16;
    localparam int OFFSET_W  = 11;
    localparam int CFG_IDX_W = 3;
    localparam int STATUS_W  = 2;
    localparam int RAW_W     = 16;
    localparam int MEAN_W    = 17;
    localparam int COUNT_W   = 16;
    localparam int RING_W    = 17;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W   = $clog2(RING_DEPTH + 1);
    localparam int SUM_W    = RING_W + FILL_W - 1;
    localparam int RING_ENTRIES = CHANNELS * RING_DEPTH;
    localparam int ADDR_W   = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT  = SAMPLE_W'(-126 * 16);
    localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT = SAMPLE_W'(185 * 16);
    localparam logic [COUNT_W-1:0]         COUNT_MAX  = '1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD  = 2'd0,
        ST_DISC  = 2'd1,
        ST_RANGE = 2'd2,
        ST_BADCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHAN,
        S_RING,
        S_DIV,
        S_WB
    } fsm_t;

    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic [FILL_W-1:0]        fill;
        logic signed [SUM_W-1:0]  sum;
        logic signed [RAW_W-1:0]  last_good;
        logic signed [MEAN_W-1:0] last_mean;
        logic [COUNT_W-1:0]       reject;
    } chan_rec_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [FILL_W-1:0]       divisor;
    } div_req_t;

endpackage

[rtl/tcqa_if.sv]
// ----------------------------------------------------------------------------
// tcqa_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface tcqa_sample_if
    import tcqa_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [CH_IN_W-1:0]         channel;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface tcqa_result_if
    import tcqa_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [RAW_W-1:0]  raw_value;
    logic signed [MEAN_W-1:0] mean_value;
    logic [COUNT_W-1:0]       error_count;

    modport source (output valid, output status, output raw_value, output mean_value,
                    output error_count, input ready);
    modport sink   (input valid, input status, input raw_value, input mean_value,
                    input error_count, output ready);
endinterface

[rtl/tcqa_div.sv]
// ----------------------------------------------------------------------------
// tcqa_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module tcqa_div
    import tcqa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    output logic                     done,
    output logic signed [MEAN_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  neg_reg;
    logic [SUM_W-1:0]      q_reg;
    logic [FILL_W-1:0]     rem_reg;
    logic [FILL_W-1:0]     div_reg;

    logic [FILL_W:0]       rem_shift;
    logic [FILL_W:0]       rem_diff;
    logic                  rem_ge;
    logic [FILL_W-1:0]     rem_next;
    logic [SUM_W-1:0]      q_next;
    logic [SUM_W-1:0]      mag;
    logic signed [SUM_W:0] q_signed;

    always_comb
    begin
        mag       = req.dividend[SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
        rem_shift = {rem_reg, q_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, div_reg};
        rem_ge    = (rem_shift >= {1'b0, div_reg});
        rem_next  = rem_ge ? rem_diff[FILL_W-1:0] : rem_shift[FILL_W-1:0];
        q_next    = {q_reg[SUM_W-2:0], rem_ge};
        q_signed  = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
            div_reg <= req.divisor;
            neg_reg <= req.dividend[SUM_W-1];
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_signed[MEAN_W-1:0];

endmodule

[rtl/temp_channel_qualifier_average.sv]
// ----------------------------------------------------------------------------
// temp_channel_qualifier_average
// Per-channel sample qualifier with a ring-buffer moving average.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                         transfer
//  samples   in   channel, sample                                 valid & ready
//  results   out  status, raw_value, mean_value, error_count      valid & ready
//  cfg       in   cfg_index, cfg_data (offset registers)          cfg_we
//
//  One item at a time. A good sample passes channel read, ring update, the
//  20-step serial divider and write-back; a rejected sample or bad channel
//  skips to write-back. The next transfer is taken the cycle after the result
//  is loaded. Channel state and ring sit in memories with registered reads.
//  Reset is asynchronous, active low; the ring is not cleared. A waiting result
//  holds the next item in write-back, and with it the sample input.
// ----------------------------------------------------------------------------
module temp_channel_qualifier_average
    import tcqa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    tcqa_sample_if.sink          samples,
    tcqa_result_if.source        results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [OFFSET_W-1:0]  cfg_data
);

    fsm_t state_reg, state_next;

    logic signed [OFFSET_W-1:0] offsets_reg [OFFSET_REGS];
    logic                       chan_valid_reg [CHANNELS];
    chan_rec_t                  chan_mem [CHANNELS];
    logic signed [RING_W-1:0]   ring_mem [RING_ENTRIES];

    chan_rec_t                  chan_rd_reg;
    logic                       chan_rd_valid_reg;
    logic signed [RING_W-1:0]   ring_rd_reg;
    logic [ADDR_W-1:0]          ring_addr_reg;
    logic [CH_IN_W-1:0]         ch_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [RING_W-1:0]   cal_reg;
    chan_rec_t                  rec_reg;
    status_t                    status_reg;

    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic signed [RAW_W-1:0]    out_raw_reg;
    logic signed [MEAN_W-1:0]   out_mean_reg;
    logic [COUNT_W-1:0]         out_err_reg;

    logic                       accept;
    logic                       in_ready;
    logic                       out_load;
    logic                       chan_we;
    logic                       ring_rd_en;
    logic                       ring_we;

    logic [CH_IDX_W-1:0]        ch_idx;
    logic [CH_IDX_W-1:0]        in_idx;
    logic                       in_bad;
    logic                       bad_ch;
    logic                       is_disc;
    logic                       is_range;
    logic                       is_reject;
    chan_rec_t                  cur;
    chan_rec_t                  cur_upd;
    logic signed [OFFSET_W-1:0] cur_offset;
    logic signed [RING_W-1:0]   cal;
    logic [ADDR_W-1:0]          ring_addr;
    logic                       ring_full;
    logic signed [RING_W-1:0]   old_entry;
    logic signed [SUM_W-1:0]    sum_new;
    logic [FILL_W-1:0]          fill_new;
    logic [SLOT_W-1:0]          slot_new;
    div_req_t                   div_req;
    logic                       div_done;
    logic signed [MEAN_W-1:0]   div_q;

    assign accept = samples.valid && in_ready;
    assign in_idx = samples.channel[CH_IDX_W-1:0];
    assign in_bad = (int'(samples.channel) >= CHANNELS);
    assign ch_idx = ch_reg[CH_IDX_W-1:0];

    // Datapath decode
    always_comb
    begin
        bad_ch     = (int'(ch_reg) >= CHANNELS);
        is_disc    = (sample_reg < LOW_LIMIT);
        is_range   = (sample_reg >= HIGH_LIMIT);
        is_reject  = is_disc || is_range;
        cur        = chan_rd_valid_reg ? chan_rd_reg : '0;
        cur_upd    = cur;
        if (is_reject && (cur.reject != COUNT_MAX))
            cur_upd.reject = cur.reject + 1'b1;
        cur_offset = (int'(ch_reg) < OFFSET_REGS) ? offsets_reg[ch_reg] : '0;
        cal        = RING_W'(sample_reg) + RING_W'(cur_offset);
        ring_addr  = ADDR_W'(ch_idx) * ADDR_W'(RING_DEPTH) + ADDR_W'(cur.slot);

        ring_full  = (rec_reg.fill >= FILL_W'(RING_DEPTH));
        old_entry  = ring_full ? ring_rd_reg : '0;
        sum_new    = rec_reg.sum - SUM_W'(old_entry) + SUM_W'(cal_reg);
        fill_new   = ring_full ? rec_reg.fill : rec_reg.fill + 1'b1;
        slot_new   = (rec_reg.slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : rec_reg.slot + 1'b1;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                    state_next = S_CHAN;
            end
            S_CHAN:
            begin
                if (bad_ch || is_reject)
                    state_next = S_WB;
                else
                    state_next = S_RING;
            end
            S_RING:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                if (!out_valid_reg || results.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready    = 1'b0;
        ring_rd_en  = 1'b0;
        ring_we     = 1'b0;
        out_load    = 1'b0;
        chan_we     = 1'b0;
        div_req     = '{start: 1'b0, dividend: sum_new, divisor: fill_new};
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_CHAN:
            begin
                ring_rd_en = !bad_ch && !is_reject;
            end
            S_RING:
            begin
                ring_we       = 1'b1;
                div_req.start = 1'b1;
            end
            S_DIV:
            begin
            end
            S_WB:
            begin
                out_load = !out_valid_reg || results.ready;
                chan_we  = out_load && !bad_ch;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < OFFSET_REGS; i++)
                offsets_reg[i] <= '0;
            for (int i = 0; i < CHANNELS; i++)
                chan_valid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we && (int'(cfg_index) < OFFSET_REGS))
                offsets_reg[cfg_index] <= cfg_data;
            if (chan_we)
                chan_valid_reg[ch_idx] <= 1'b1;
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (accept && !in_bad)
        begin
            chan_rd_reg       <= chan_mem[in_idx];
            chan_rd_valid_reg <= chan_valid_reg[in_idx];
        end
        if (chan_we)
            chan_mem[ch_idx] <= rec_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ring_rd_en)
            ring_rd_reg <= ring_mem[ring_addr];
        if (ring_we)
            ring_mem[ring_addr_reg] <= cal_reg;
    end

    // Working record and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg     <= samples.channel;
            sample_reg <= samples.sample;
        end
        unique case (state_reg)
            S_CHAN:
            begin
                rec_reg       <= cur_upd;
                cal_reg       <= cal;
                ring_addr_reg <= ring_addr;
                if (bad_ch)
                    status_reg <= ST_BADCH;
                else if (is_disc)
                    status_reg <= ST_DISC;
                else if (is_range)
                    status_reg <= ST_RANGE;
                else
                    status_reg <= ST_GOOD;
            end
            S_RING:
            begin
                rec_reg.sum       <= sum_new;
                rec_reg.fill      <= fill_new;
                rec_reg.slot      <= slot_new;
                rec_reg.last_good <= sample_reg;
            end
            S_DIV:
            begin
                if (div_done)
                    rec_reg.last_mean <= div_q;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_raw_reg    <= bad_ch ? '0 : rec_reg.last_good;
            out_mean_reg   <= bad_ch ? '0 : rec_reg.last_mean;
            out_err_reg    <= bad_ch ? '0 : rec_reg.reject;
        end
    end

    tcqa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign samples.ready       = in_ready;
    assign results.valid       = out_valid_reg;
    assign results.status      = out_status_reg;
    assign results.raw_value   = out_raw_reg;
    assign results.mean_value  = out_mean_reg;
    assign results.error_count = out_err_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_accept_to_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> state_reg == S_CHAN)
        else $error("transfer did not start channel read");

    a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_WB)
        else $error("result raised outside write-back");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chan_we |-> rec_reg.fill <= FILL_W'(RING_DEPTH))
        else $error("fill count beyond ring depth");
`endif

endmodule
